@@ sv/tdc_pkg.sv @@
`timescale 1ns / 1ps

package tdc_pkg;

  // Default geometry
  localparam int COORD_BITS_DEF    = 24;
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int ATAN_ENTRIES      = 24;

  // Binary angle units: full turn = 2^32
  localparam logic [31:0] HALF_TURN = 32'h8000_0000;
  localparam int          PROD_W    = 41;          // mag * 360 fits below 2^41
  localparam logic [8:0]  DEG_FULL  = 9'd360;

  // Configuration register indexes
  localparam logic [7:0] REG_STRAIGHT_LIMIT = 8'd0;
  localparam logic [7:0] REG_NOWAY_LIMIT    = 8'd1;

  localparam logic [7:0] STRAIGHT_LIMIT_RST = 8'd20;
  localparam logic [7:0] NOWAY_LIMIT_RST    = 8'd100;

  // Result codes
  typedef enum logic [1:0] {
    TURN_MIDDLE = 2'd0,
    TURN_LEFT   = 2'd1,
    TURN_RIGHT  = 2'd2,
    TURN_NOWAY  = 2'd3
  } turn_t;

  // Side info that travels with each item through the CORDIC stages
  typedef struct packed {
    logic       straight;  // next segment is straight
    logic       mismatch;  // joint stations differ
    logic [2:0] zero;      // per lane: zero-length vector
  } meta_t;

  // atan(2^-i) in binary angle units
  function automatic logic [31:0] atan_bam(input int unsigned idx);
    logic [31:0] a;
    case (idx)
      0:  a = 32'h2000_0000;
      1:  a = 32'h12E4_051E;
      2:  a = 32'h09FB_385B;
      3:  a = 32'h0511_11D4;
      4:  a = 32'h028B_0D43;
      5:  a = 32'h0145_D7E1;
      6:  a = 32'h00A2_F61E;
      7:  a = 32'h0051_7C55;
      8:  a = 32'h0028_BE53;
      9:  a = 32'h0014_5F2F;
      10: a = 32'h000A_2F98;
      11: a = 32'h0005_17CC;
      12: a = 32'h0002_8BE6;
      13: a = 32'h0001_45F3;
      14: a = 32'h0000_A2FA;
      15: a = 32'h0000_517D;
      16: a = 32'h0000_28BE;
      17: a = 32'h0000_145F;
      18: a = 32'h0000_0A30;
      19: a = 32'h0000_0518;
      20: a = 32'h0000_028C;
      21: a = 32'h0000_0146;
      22: a = 32'h0000_00A3;
      23: a = 32'h0000_0051;
      default: a = 32'h0000_0000;
    endcase
    return a;
  endfunction

endpackage

@@ sv/turn_direction_classifier_top.sv @@
`timescale 1ns / 1ps

// Pipeline: input differences, CORDIC pre-rotation, the CORDIC iterations, heading difference,
//   degree scaling, then the output register that drives turn_code.
// Throughput: one item per cycle while the skid buffer is empty; three unrolled CORDIC lanes, one stage per iteration.
// The output register plus a one-entry skid buffer keep input open while one result
//   waits; input stalls only while the skid buffer also holds a result.
// Reset (rst, synchronous): empties the pipeline and output, limits go to 20 and 100 deg.
module turn_direction_classifier_top #(
  parameter int COORD_BITS    = tdc_pkg::COORD_BITS_DEF,
  parameter int CORDIC_STAGES = tdc_pkg::CORDIC_STAGES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  // configuration
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [7:0]                   cfg_index,
  input  logic [7:0]                   cfg_data,
  // input items
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] last_ref_x,
  input  logic signed [COORD_BITS-1:0] last_ref_y,
  input  logic signed [COORD_BITS-1:0] joint_x,
  input  logic signed [COORD_BITS-1:0] joint_y,
  input  logic signed [COORD_BITS-1:0] next_end_x,
  input  logic signed [COORD_BITS-1:0] next_end_y,
  input  logic                         next_straight,
  input  logic signed [COORD_BITS-1:0] next_ctrl_x,
  input  logic signed [COORD_BITS-1:0] next_ctrl_y,
  input  logic [15:0]                  last_end_station,
  input  logic [15:0]                  next_start_station,
  // results
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   turn_code
);

  localparam int N    = CORDIC_STAGES;
  localparam int DW   = COORD_BITS + 1;  // difference width
  localparam int W    = COORD_BITS + 3;  // CORDIC datapath width, covers gain
  localparam int S    = N + 4;           // pipeline stages before output register
  localparam int PW   = tdc_pkg::PROD_W;

  // ---------------------------------------------------------------
  // Configuration registers
  logic [7:0] straight_limit_deg;
  logic [7:0] noway_limit_deg;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      straight_limit_deg <= tdc_pkg::STRAIGHT_LIMIT_RST;
      noway_limit_deg    <= tdc_pkg::NOWAY_LIMIT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        tdc_pkg::REG_STRAIGHT_LIMIT: straight_limit_deg <= cfg_data;
        tdc_pkg::REG_NOWAY_LIMIT:    noway_limit_deg    <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------
  // Pipeline control: whole pipe moves unless the skid buffer holds a result
  logic         skid_full;
  logic         en;
  logic [S-1:0] vld;
  logic         pipe_out_valid;

  assign en             = !skid_full;
  assign in_ready       = en;
  assign pipe_out_valid = vld[S-1] && en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[S-2:0], in_valid};
    end
  end

  // ---------------------------------------------------------------
  // Stage 0: heading vectors for the three lanes
  //   lane 0: incoming, lane 1: outgoing, lane 2: chord to next end
  logic signed [DW-1:0] s0_dx [0:2];
  logic signed [DW-1:0] s0_dy [0:2];
  tdc_pkg::meta_t       s0_meta;

  logic signed [COORD_BITS-1:0] out_tx, out_ty;
  assign out_tx = next_straight ? next_end_x : next_ctrl_x;
  assign out_ty = next_straight ? next_end_y : next_ctrl_y;

  always_ff @(posedge clk) begin
    if (en) begin
      s0_dx[0] <= DW'(joint_x) - DW'(last_ref_x);
      s0_dy[0] <= DW'(joint_y) - DW'(last_ref_y);
      s0_dx[1] <= DW'(out_tx) - DW'(joint_x);
      s0_dy[1] <= DW'(out_ty) - DW'(joint_y);
      s0_dx[2] <= DW'(next_end_x) - DW'(joint_x);
      s0_dy[2] <= DW'(next_end_y) - DW'(joint_y);
      s0_meta.straight <= next_straight;
      s0_meta.mismatch <= (last_end_station != next_start_station);
      s0_meta.zero     <= '0;
    end
  end

  // ---------------------------------------------------------------
  // CORDIC state: index 0 after pre-rotation, index k+1 after iteration k
  logic signed [W-1:0] cx [0:N][0:2];
  logic signed [W-1:0] cy [0:N][0:2];
  logic [31:0]         cz [0:N][0:2];
  tdc_pkg::meta_t      cm [0:N];

  // Pre-rotation into the right half plane, zero-vector detect
  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        if (s0_dx[l][DW-1]) begin
          cx[0][l] <= -W'(s0_dx[l]);
          cy[0][l] <= -W'(s0_dy[l]);
          cz[0][l] <= tdc_pkg::HALF_TURN;
        end else begin
          cx[0][l] <= W'(s0_dx[l]);
          cy[0][l] <= W'(s0_dy[l]);
          cz[0][l] <= '0;
        end
      end
      cm[0].straight <= s0_meta.straight;
      cm[0].mismatch <= s0_meta.mismatch;
      for (int l = 0; l < 3; l++) begin
        cm[0].zero[l] <= (s0_dx[l] == '0) && (s0_dy[l] == '0);
      end
    end
  end

  // Vectoring iterations, one register stage each
  for (genvar k = 0; k < N; k++) begin : g_cordic
    always_ff @(posedge clk) begin
      if (en) begin
        for (int l = 0; l < 3; l++) begin
          if (!cy[k][l][W-1] && (cy[k][l] != '0)) begin
            cx[k+1][l] <= cx[k][l] + (cy[k][l] >>> k);
            cy[k+1][l] <= cy[k][l] - (cx[k][l] >>> k);
            cz[k+1][l] <= cz[k][l] + tdc_pkg::atan_bam(k);
          end else begin
            cx[k+1][l] <= cx[k][l] - (cy[k][l] >>> k);
            cy[k+1][l] <= cy[k][l] + (cx[k][l] >>> k);
            cz[k+1][l] <= cz[k][l] - tdc_pkg::atan_bam(k);
          end
        end
        cm[k+1] <= cm[k];
      end
    end
  end

  // ---------------------------------------------------------------
  // Heading differences, wrapped magnitude and sign
  logic [31:0] h_last, h_next, h_chord;
  logic [31:0] dd, dd2;
  assign h_last  = cm[N].zero[0] ? 32'd0 : cz[N][0];
  assign h_next  = cm[N].zero[1] ? 32'd0 : cz[N][1];
  assign h_chord = cm[N].zero[2] ? 32'd0 : cz[N][2];
  assign dd      = h_next - h_last;
  assign dd2     = h_chord - h_last;

  logic [31:0] d_mag, d_mag2;
  logic        d_pos, d_pos2, d_straight, d_mismatch;

  always_ff @(posedge clk) begin
    if (en) begin
      d_mag      <= (dd <= tdc_pkg::HALF_TURN) ? dd : (32'd0 - dd);
      d_mag2     <= (dd2 <= tdc_pkg::HALF_TURN) ? dd2 : (32'd0 - dd2);
      d_pos      <= (dd != '0) && (dd <= tdc_pkg::HALF_TURN);
      d_pos2     <= (dd2 != '0) && (dd2 <= tdc_pkg::HALF_TURN);
      d_straight <= cm[N].straight;
      d_mismatch <= cm[N].mismatch;
    end
  end

  // ---------------------------------------------------------------
  // Scale to degrees: |d| * 360, compared later with limit * 2^32
  logic [PW-1:0] m_prod, m_prod2;
  logic          m_pos, m_pos2, m_straight, m_mismatch;

  always_ff @(posedge clk) begin
    if (en) begin
      m_prod     <= PW'({9'd0, d_mag} * {32'd0, tdc_pkg::DEG_FULL});
      m_prod2    <= PW'({9'd0, d_mag2} * {32'd0, tdc_pkg::DEG_FULL});
      m_pos      <= d_pos;
      m_pos2     <= d_pos2;
      m_straight <= d_straight;
      m_mismatch <= d_mismatch;
    end
  end

  // ---------------------------------------------------------------
  // Classification
  logic [PW-1:0] lim_straight, lim_noway;
  logic          in_straight, in_straight2, at_noway;
  tdc_pkg::turn_t code;

  assign lim_straight = {1'b0, straight_limit_deg, 32'd0};
  assign lim_noway    = {1'b0, noway_limit_deg, 32'd0};
  assign in_straight  = (m_prod <= lim_straight);
  assign in_straight2 = (m_prod2 <= lim_straight);
  assign at_noway     = (m_prod >= lim_noway);

  always_comb begin
    if (m_mismatch) begin
      code = tdc_pkg::TURN_NOWAY;
    end else if (in_straight) begin
      if (m_straight || in_straight2) begin
        code = tdc_pkg::TURN_MIDDLE;
      end else begin
        code = m_pos2 ? tdc_pkg::TURN_RIGHT : tdc_pkg::TURN_LEFT;
      end
    end else if (at_noway) begin
      code = tdc_pkg::TURN_NOWAY;
    end else begin
      code = m_pos ? tdc_pkg::TURN_RIGHT : tdc_pkg::TURN_LEFT;
    end
  end

  // ---------------------------------------------------------------
  // Output register with one-entry skid buffer
  logic [1:0] skid_code;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_full <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_full) begin
        out_valid <= 1'b1;
        skid_full <= 1'b0;
      end else begin
        out_valid <= pipe_out_valid;
      end
    end else if (pipe_out_valid) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      turn_code <= skid_full ? skid_code : code;
    end else if (pipe_out_valid) begin
      skid_code <= code;
    end
  end

  // ---------------------------------------------------------------
  // Assertions
  a_skid_needs_out : assert property (@(posedge clk) disable iff (rst)
    skid_full |-> out_valid)
    else $error("skid buffer holds a result while output is empty");

  a_stall_freezes : assert property (@(posedge clk) disable iff (rst)
    !in_ready |=> $stable(vld))
    else $error("pipeline valid bits moved during a stall");

  a_mismatch_noway : assert property (@(posedge clk) disable iff (rst)
    pipe_out_valid && m_mismatch && (!out_valid || out_ready)
    |=> out_valid && (turn_code == tdc_pkg::TURN_NOWAY))
    else $error("station mismatch did not give no way");

  a_no_overflow : assert property (@(posedge clk) disable iff (rst)
    pipe_out_valid && out_valid && !out_ready |=> skid_full)
    else $error("result lost while output stalled");

endmodule
